// ===== rtl/rfsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsc_pkg: shared types and constants for the RGB frame statistics check
// Controller states, arithmetic phases, command/status bundles and registers.
// ----------------------------------------------------------------------------
package rfsc_pkg;

  localparam int DEF_COUNT_BITS = 20;
  localparam int PIX_W          = 8;
  localparam int LIMIT_W        = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int MEAN_W         = 16;
  localparam int VAR_W          = 32;
  localparam int ROOT_W         = 16;
  localparam int CHAN_W         = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT = 3'd4;

  localparam logic [LIMIT_W-1:0] RST_BLUE_LIMIT   = 8'd128;
  localparam logic [LIMIT_W-1:0] RST_GREEN_LOW    = 8'd3;
  localparam logic [LIMIT_W-1:0] RST_GREEN_HIGH   = 8'd128;
  localparam logic [LIMIT_W-1:0] RST_RED_FLOOR    = 8'd128;
  localparam logic [LIMIT_W-1:0] RST_SPREAD_LIMIT = 8'd40;

  localparam logic [CHAN_W-1:0] CHAN_BLUE  = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_RED   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_LOAD, ST_RUN, ST_CHECK, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_MUL_M, PH_MUL_P, PH_MUL_Q, PH_DIV_MEAN, PH_DIV_VAR, PH_SQRT
  } phase_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] blue_limit;
    logic [LIMIT_W-1:0] green_low;
    logic [LIMIT_W-1:0] green_high;
    logic [LIMIT_W-1:0] red_floor;
    logic [LIMIT_W-1:0] spread_limit;
  } limits_t;

  typedef struct packed {
    logic              accum;
    logic              start;
    logic              step;
    logic              save_m;
    logic              check;
    logic              init_ok;
    logic              emit;
    phase_t            phase;
    logic [CHAN_W-1:0] chan;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_bad;
  } dp_status_t;

endpackage

// ===== rtl/rfsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsc_datapath: accumulators and serial arithmetic
// Per-channel sums, shift-add multiplier, restoring divider, square root.
// ----------------------------------------------------------------------------
module rfsc_datapath #(
  parameter int COUNT_BITS = rfsc_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rfsc_pkg::PIX_W-1:0]    blue_value,
  input  logic [rfsc_pkg::PIX_W-1:0]    green_value,
  input  logic [rfsc_pkg::PIX_W-1:0]    red_value,
  input  rfsc_pkg::dp_cmd_t             cmd,
  input  rfsc_pkg::limits_t             limits,
  output rfsc_pkg::dp_status_t          status,
  output logic                          frame_ok
);
  import rfsc_pkg::*;

  localparam int CNT_W  = COUNT_BITS + 1;
  localparam int SUM_W  = CNT_W + 8;
  localparam int SQ_W   = CNT_W + 16;
  localparam int PROD_W = SQ_W + CNT_W;
  localparam int M_W    = 2 * CNT_W;
  localparam int NUM_W  = PROD_W + 16;

  logic [CNT_W-1:0]  pixel_count;
  logic              count_overflow;
  logic [SUM_W-1:0]  channel_sum [3];
  logic [SQ_W-1:0]   channel_square_sum [3];

  logic [PROD_W-1:0] prod, mcand, p_reg;
  logic [SUM_W-1:0]  mplier;
  logic [M_W-1:0]    m_reg, den, rem;
  logic [NUM_W-1:0]  num;
  logic [MEAN_W-1:0] mean_reg;
  logic [VAR_W-1:0]  sv;
  logic [ROOT_W+1:0] sq_rem;
  logic [ROOT_W-1:0] root;
  logic              ok_reg;

  logic [SUM_W-1:0]  sum_sel;
  logic [SQ_W-1:0]   sq_sel;
  logic [PIX_W-1:0]  px [3];
  logic [M_W:0]      rem_sh;
  logic              div_ge;
  logic [ROOT_W+3:0] rs, trial;
  logic              sq_ge;
  logic [MEAN_W:0]   plus, red_rhs;
  logic              chan_ok;

  assign px[0] = blue_value;
  assign px[1] = green_value;
  assign px[2] = red_value;

  assign status.frame_bad = count_overflow || (pixel_count < CNT_W'(2));

  always_comb begin
    unique case (cmd.chan)
      CHAN_GREEN: begin
        sum_sel = channel_sum[1];
        sq_sel  = channel_square_sum[1];
      end
      CHAN_RED: begin
        sum_sel = channel_sum[2];
        sq_sel  = channel_square_sum[2];
      end
      default: begin
        sum_sel = channel_sum[0];
        sq_sel  = channel_square_sum[0];
      end
    endcase
  end

  // Restoring divide step and square-root step.
  assign rem_sh = {rem, num[NUM_W-1]};
  assign div_ge = rem_sh >= {1'b0, den};
  assign rs     = {sq_rem, sv[VAR_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign sq_ge  = rs >= trial;

  assign plus    = {1'b0, mean_reg} + {1'b0, root};
  assign red_rhs = {1'b0, root} + {1'b0, limits.red_floor, 8'h00};

  always_comb begin
    chan_ok = root < {limits.spread_limit, 8'h00};
    case (cmd.chan)
      CHAN_BLUE:  chan_ok = chan_ok && (plus < {1'b0, limits.blue_limit, 8'h00});
      CHAN_GREEN: chan_ok = chan_ok && (plus > {1'b0, limits.green_low, 8'h00})
                                    && (plus < {1'b0, limits.green_high, 8'h00});
      default:    chan_ok = chan_ok && ({1'b0, mean_reg} >= red_rhs);
    endcase
  end

  // Accumulators; clear on reset and when the result is emitted to the output register.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      pixel_count    <= '0;
      count_overflow <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        channel_sum[c]        <= '0;
        channel_square_sum[c] <= '0;
      end
    end else if (cmd.accum) begin
      if (pixel_count[CNT_W-1]) begin
        count_overflow <= 1'b1;
      end else begin
        pixel_count <= pixel_count + CNT_W'(1);
        for (int c = 0; c < 3; c++) begin
          channel_sum[c]        <= channel_sum[c] + SUM_W'(px[c]);
          channel_square_sum[c] <= channel_square_sum[c] + SQ_W'(px[c] * px[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      unique case (cmd.phase)
        PH_MUL_M: begin
          prod   <= '0;
          mcand  <= PROD_W'(pixel_count);
          mplier <= SUM_W'(pixel_count - CNT_W'(1));
        end
        PH_MUL_P: begin
          if (cmd.save_m) begin
            m_reg <= prod[M_W-1:0];
          end
          prod   <= '0;
          mcand  <= PROD_W'(sq_sel);
          mplier <= SUM_W'(pixel_count);
        end
        PH_MUL_Q: begin
          p_reg  <= prod;
          prod   <= '0;
          mcand  <= PROD_W'(sum_sel);
          mplier <= sum_sel;
        end
        PH_DIV_MEAN: begin
          num <= NUM_W'({sum_sel, 8'h00});
          den <= M_W'(pixel_count);
          rem <= '0;
        end
        PH_DIV_VAR: begin
          mean_reg <= num[MEAN_W-1:0];
          num      <= {p_reg - prod, 16'h0000};
          den      <= m_reg;
          rem      <= '0;
        end
        PH_SQRT: begin
          sv     <= num[VAR_W-1:0];
          sq_rem <= '0;
          root   <= '0;
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      unique case (cmd.phase)
        PH_MUL_M, PH_MUL_P, PH_MUL_Q: begin
          if (mplier[0]) begin
            prod <= prod + mcand;
          end
          mcand  <= {mcand[PROD_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[SUM_W-1:1]};
        end
        PH_DIV_MEAN, PH_DIV_VAR: begin
          rem <= div_ge ? M_W'(rem_sh - {1'b0, den}) : rem_sh[M_W-1:0];
          num <= {num[NUM_W-2:0], div_ge};
        end
        PH_SQRT: begin
          sq_rem <= sq_ge ? (ROOT_W+2)'(rs - trial) : rs[ROOT_W+1:0];
          root   <= {root[ROOT_W-2:0], sq_ge};
          sv     <= {sv[VAR_W-3:0], 2'b00};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_ok) begin
      ok_reg <= !status.frame_bad;
    end else if (cmd.check) begin
      ok_reg <= ok_reg && chan_ok;
    end
    if (cmd.emit) begin
      frame_ok <= ok_reg;
    end
  end

endmodule

// ===== rtl/rfsc_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsc_controller: sequencer for the frame statistics check
// Accepts pixels, then steps the datapath through each channel's math, or goes straight to the result for a bad frame.
// ----------------------------------------------------------------------------
module rfsc_controller #(
  parameter int COUNT_BITS = rfsc_pkg::DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rfsc_pkg::dp_status_t status,
  output rfsc_pkg::dp_cmd_t    cmd
);
  import rfsc_pkg::*;

  localparam int CNT_W  = COUNT_BITS + 1;
  localparam int SUM_W  = CNT_W + 8;
  localparam int PROD_W = 2 * CNT_W + 16;
  localparam int NUM_W  = PROD_W + 16;
  localparam int CTR_W  = $clog2(NUM_W);

  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [CHAN_W-1:0] chan, chan_next;
  logic [CTR_W-1:0]  counter, counter_next;
  logic              out_valid_next;
  logic [CTR_W-1:0]  load_steps;

  always_comb begin
    case (phase)
      PH_DIV_MEAN, PH_DIV_VAR: load_steps = CTR_W'(NUM_W - 1);
      PH_SQRT:                 load_steps = CTR_W'(ROOT_W - 1);
      default:                 load_steps = CTR_W'(SUM_W - 1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_MUL_M;
      chan      <= CHAN_BLUE;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      chan      <= chan_next;
      counter   <= counter_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    chan_next      = chan;
    counter_next   = counter;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.phase      = phase;
    cmd.chan       = chan;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (frame_end) begin
            state_next = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        cmd.init_ok = 1'b1;
        phase_next  = PH_MUL_M;
        chan_next   = CHAN_BLUE;
        state_next  = status.frame_bad ? ST_DONE : ST_LOAD;
      end
      ST_LOAD: begin
        cmd.start    = 1'b1;
        cmd.save_m   = (phase == PH_MUL_P) && (chan == CHAN_BLUE);
        counter_next = load_steps;
        state_next   = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (counter == '0) begin
          unique case (phase)
            PH_MUL_M:    phase_next = PH_MUL_P;
            PH_MUL_P:    phase_next = PH_MUL_Q;
            PH_MUL_Q:    phase_next = PH_DIV_MEAN;
            PH_DIV_MEAN: phase_next = PH_DIV_VAR;
            PH_DIV_VAR:  phase_next = PH_SQRT;
            default:     phase_next = PH_SQRT;
          endcase
          state_next = (phase == PH_SQRT) ? ST_CHECK : ST_LOAD;
        end else begin
          counter_next = counter - CTR_W'(1);
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (chan == CHAN_RED) begin
          state_next = ST_DONE;
        end else begin
          chan_next  = chan + CHAN_W'(1);
          phase_next = PH_MUL_P;
          state_next = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/rgb_frame_statistics_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_frame_statistics_check: per-frame RGB mean/deviation pass check
// Config registers, controller and datapath of the frame statistics block.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels arrive on the in_valid/in_ready channel, one transfer per cycle
//   while the block is collecting; frame_end marks the last pixel of a frame.
//   Each pixel updates the count and per-channel sum and sum of squares.
//   After the frame_end transfer the block stops taking pixels and computes,
//   channel by channel, mean and sample deviation with one shift-add
//   multiplier, one restoring divider and one square-root unit, one bit
//   (two for the root) per cycle. A frame with under two pixels or an
//   overflowed count skips straight to a fail result. One frame_ok
//   transfer goes out on out_valid/out_ready per frame; it is held in an
//   output register, so pixels of the next frame are taken while it waits.
//   A stalled result only holds the next frame-end result back.
//   Configuration writes land at once (cfg_ready is always high).
//   Reset clears the accumulators, drops any pending result and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module rgb_frame_statistics_check #(
  parameter int COUNT_BITS = rfsc_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rfsc_pkg::PIX_W-1:0]        blue_value,
  input  logic [rfsc_pkg::PIX_W-1:0]        green_value,
  input  logic [rfsc_pkg::PIX_W-1:0]        red_value,
  input  logic                              frame_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              frame_ok,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rfsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfsc_pkg::LIMIT_W-1:0]      cfg_data
);
  import rfsc_pkg::*;

  limits_t    limits;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Register writes are taken at once and never stall the port.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.blue_limit   <= RST_BLUE_LIMIT;
      limits.green_low    <= RST_GREEN_LOW;
      limits.green_high   <= RST_GREEN_HIGH;
      limits.red_floor    <= RST_RED_FLOOR;
      limits.spread_limit <= RST_SPREAD_LIMIT;
    end else if (cfg_valid) begin
      // Drop writes to unknown indexes.
      unique case (cfg_index)
        REG_BLUE_LIMIT:   limits.blue_limit   <= cfg_data;
        REG_GREEN_LOW:    limits.green_low    <= cfg_data;
        REG_GREEN_HIGH:   limits.green_high   <= cfg_data;
        REG_RED_FLOOR:    limits.red_floor    <= cfg_data;
        REG_SPREAD_LIMIT: limits.spread_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: handshakes and phase/channel stepping.
  rfsc_controller #(
    .COUNT_BITS (COUNT_BITS)
  ) u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Accumulators, serial arithmetic and the pass checks.
  rfsc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .blue_value  (blue_value),
    .green_value (green_value),
    .red_value   (red_value),
    .cmd         (cmd),
    .limits      (limits),
    .status      (status),
    .frame_ok    (frame_ok)
  );

endmodule

// ===== tb/rgb_frame_statistics_check_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_frame_statistics_check_test: self-checking bench for the frame checker
// Sends RGB frames over the pixel channel, predicts each frame_ok verdict from
// running sums and compares it with the block's result transfers in order.
// ----------------------------------------------------------------------------
module rgb_frame_statistics_check_test;
  import rfsc_pkg::*;

  // Shrink the pixel counter so overflowing frames stay short.
  localparam int CNT_BITS    = 6;
  localparam int FRAME_CAP   = 1 << CNT_BITS;
  localparam int ITEM_TARGET = 1150;
  localparam int SETTLE      = 600;
  localparam int HOLD_CYCLES = 3000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     blue_value = '0;
  logic [PIX_W-1:0]     green_value = '0;
  logic [PIX_W-1:0]     red_value = '0;
  logic                 frame_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 frame_ok;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  rgb_frame_statistics_check #(.COUNT_BITS(CNT_BITS)) DUT (
    .clk, .rst, .in_valid, .in_ready, .blue_value, .green_value, .red_value,
    .frame_end, .out_valid, .out_ready, .frame_ok, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block: limits, running sums and the verdicts still owed.
  limits_t          lim;
  longint unsigned  pix_n;
  longint unsigned  sum_c [3];
  longint unsigned  sq_c [3];
  bit               count_ovf;
  bit               verdicts_due [$];

  int  pixels_sent = 0;
  int  mismatches  = 0;
  bit  quiet       = 1'b0;  // no idling on either side while set
  bit  held_once   = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 32;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic bit frame_verdict();
    longint mean_q [3];
    longint dev_q [3];
    longint unsigned d, m, v;
    longint spread;
    if (count_ovf || pix_n < 2) return 1'b0;
    for (int c = 0; c < 3; c++) begin
      d = pix_n * sq_c[c] - sum_c[c] * sum_c[c];
      m = pix_n * (pix_n - 1);
      v = (d / m) * 65536 + ((d % m) * 65536) / m;
      mean_q[c] = longint'((sum_c[c] * 256) / pix_n);
      dev_q[c]  = longint'(int_sqrt(v));
    end
    spread = longint'(lim.spread_limit) * 256;
    return (mean_q[0] + dev_q[0] < longint'(lim.blue_limit) * 256) &&
           (mean_q[1] + dev_q[1] > longint'(lim.green_low) * 256) &&
           (mean_q[1] + dev_q[1] < longint'(lim.green_high) * 256) &&
           (mean_q[2] - dev_q[2] >= longint'(lim.red_floor) * 256) &&
           (dev_q[0] < spread) && (dev_q[1] < spread) && (dev_q[2] < spread);
  endfunction

  function automatic void clear_sums();
    pix_n = 0;
    count_ovf = 1'b0;
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = 0;
      sq_c[c]  = 0;
    end
  endfunction

  // Fold one accepted pixel into the sums; on frame end, queue the verdict.
  function automatic void absorb_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                       logic fe, bit typed, bit typed_ok);
    longint unsigned px [3];
    bit ok;
    px[0] = 64'(b);
    px[1] = 64'(g);
    px[2] = 64'(r);
    if (pix_n >= FRAME_CAP) begin
      count_ovf = 1'b1;
    end else begin
      pix_n++;
      for (int c = 0; c < 3; c++) begin
        sum_c[c] += px[c];
        sq_c[c]  += px[c] * px[c];
      end
    end
    if (fe) begin
      ok = typed ? typed_ok : frame_verdict();
      verdicts_due.push_back(ok);
      clear_sums();
    end
  endfunction

  // Offer one pixel, sometimes after a random gap, and hold it until the transfer.
  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fe,
                            bit typed = 1'b0, bit typed_ok = 1'b0);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    blue_value  <= b;
    green_value <= g;
    red_value   <= r;
    frame_end   <= fe;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    absorb_pixel(b, g, r, fe, typed, typed_ok);
  endtask

  // Drop valid and wait until every verdict is back and the block is idle.
  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BLUE_LIMIT:   lim.blue_limit   = val;
      REG_GREEN_LOW:    lim.green_low    = val;
      REG_GREEN_HIGH:   lim.green_high   = val;
      REG_RED_FLOOR:    lim.red_floor    = val;
      REG_SPREAD_LIMIT: lim.spread_limit = val;
      default: ;  // unmapped index: block ignores it
    endcase
  endtask

  task automatic load_limits(logic [7:0] bl, logic [7:0] gl, logic [7:0] gh,
                             logic [7:0] rf, logic [7:0] sl);
    write_reg(REG_BLUE_LIMIT, bl);
    write_reg(REG_GREEN_LOW, gl);
    write_reg(REG_GREEN_HIGH, gh);
    write_reg(REG_RED_FLOOR, rf);
    write_reg(REG_SPREAD_LIMIT, sl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] near(int center, int width);
    int v;
    v = center + $urandom_range(0, 2 * width) - width;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // One random frame: mostly clustered pixels so verdicts go both ways.
  task automatic send_random_frame();
    int len, pick, w;
    int cb, cg, cr;
    bit noisy;
    pick = $urandom_range(0, 99);
    if (pick < 8) len = 1;
    else if (pick < 15) len = $urandom_range(FRAME_CAP - 2, FRAME_CAP + 6);
    else if (pick < 20) len = $urandom_range(25, 50);
    else len = $urandom_range(2, 24);
    noisy = ($urandom_range(0, 3) == 0);
    w  = $urandom_range(0, 40);
    cb = $urandom_range(0, 255);
    cg = $urandom_range(0, 255);
    cr = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      if (noisy)
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), i == len - 1);
      else
        send_pixel(near(cb, w), near(cg, w), near(cr, w), i == len - 1);
    end
  endtask

  typedef struct {
    logic [7:0] b, g, r;
    logic       fe;
    bit         typed;
    bit         ok;
  } pixel_row_t;

  // Directed frames under reset limits; verdicts typed where obvious.
  pixel_row_t directed [] = '{
    '{8'd10,  8'd10,  8'd10,  1'b1, 1'b1, 1'b0},  // single-pixel frame fails
    '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
    '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b0},  // black: green too low
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0},  // white: blue too high
    '{8'd50,  8'd50,  8'd200, 1'b0, 1'b0, 1'b0},
    '{8'd50,  8'd50,  8'd200, 1'b1, 1'b1, 1'b1},  // flat, inside every bound
    '{8'd20,  8'd40,  8'd150, 1'b0, 1'b0, 1'b0},
    '{8'd30,  8'd60,  8'd170, 1'b0, 1'b0, 1'b0},
    '{8'd25,  8'd50,  8'd160, 1'b1, 1'b0, 1'b0},
    '{8'd50,  8'd50,  8'd200, 1'b0, 1'b0, 1'b0},
    '{8'd50,  8'd50,  8'd255, 1'b1, 1'b0, 1'b0},  // red spread just under limit
    '{8'd100, 8'd120, 8'd128, 1'b0, 1'b0, 1'b0},
    '{8'd1,   8'd2,   8'd127, 1'b1, 1'b0, 1'b0}
  };

  // Stimulus: directed rows, then random frames under several limit sets.
  initial begin
    lim = '{RST_BLUE_LIMIT, RST_GREEN_LOW, RST_GREEN_HIGH, RST_RED_FLOOR,
            RST_SPREAD_LIMIT};
    clear_sums();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_pixel(directed[i].b, directed[i].g, directed[i].r, directed[i].fe,
                 directed[i].typed, directed[i].ok);
    for (int ph = 0; pixels_sent < ITEM_TARGET; ph++) begin
      drain(SETTLE);
      case (ph % 6)
        0: load_limits(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        1: load_limits(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        2: load_limits(8'd200, 8'd10, 8'd200, 8'd20, 8'd100);
        3: begin
          // unmapped indexes must leave the limits alone
          write_reg(3'd5, 8'hFF);
          write_reg(3'd6, 8'h00);
          write_reg(3'd7, 8'hA5);
          load_limits(8'd240, 8'd5, 8'd250, 8'd30, 8'd60);
        end
        default: load_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)),
                             8'($urandom_range(100, 255)), 8'($urandom_range(0, 160)),
                             8'($urandom_range(10, 255)));
      endcase
      // Random frames until the next limit change or the item budget runs out.
      while (pixels_sent < ITEM_TARGET && pixels_sent < (ph + 1) * 190 + 30) begin
        quiet = (pixels_sent >= 450 && pixels_sent < 620);
        if (pixels_sent >= 800 && pixels_sent < 860)
          drain(0);  // sender pauses until every verdict is back
        send_random_frame();
      end
    end
    drain(SETTLE);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("rgb_frame_statistics_check_test OK");
    end else begin
      $display("rgb_frame_statistics_check_test NOT OK");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    @(posedge clk);
    forever begin
      if (!held_once && pixels_sent >= 300) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 6);
        @(posedge clk);
      end
    end
  end

  // Compare each frame_ok transfer with the oldest owed verdict.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected frame_ok transfer: %b", frame_ok);
      end else if (frame_ok !== verdicts_due[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame_ok mismatch: expected %b actual %b", verdicts_due[0], frame_ok);
        void'(verdicts_due.pop_front());
      end else begin
        void'(verdicts_due.pop_front());
      end
    end
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("rgb_frame_statistics_check_test NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rfsc_pkg.sv
rtl/rfsc_datapath.sv
rtl/rfsc_controller.sv
rtl/rgb_frame_statistics_check.sv
tb/rgb_frame_statistics_check_test.sv
